[sv/binary_to_decimal_ascii_defines.svh]
// Assertion macros for the binary to decimal ASCII converter checker.
// Depends on nothing; the including scope must provide clk and rst_n.
// An include guard keeps the macros from being defined twice.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B2DA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/b2da_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and sizing function of the decimal ASCII converter.
// Depends on nothing; every other file but the assertion macro header imports it.
package b2da_pkg;

  // Default width of the binary input value.
  localparam int DEF_VALUE_WIDTH = 32;

  // Field widths of one result item.
  localparam int CHAR_W  = 6;
  localparam int COUNT_W = 4;
  localparam int DIGIT_W = 4;

  // ASCII code of the character '0'.
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Decimal digits needed for the largest value of a given bit width.
  // 1233 / 4096 approximates log10(2) closely enough up to 64 bits.
  function automatic int b2da_num_digits(input int width);
    return ((width * 1233) >> 12) + 1;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new value and clear the BCD digits
    logic shift;   // one adjust-and-shift step of the conversion
    logic count;   // find the leading digit and the digit count
    logic emit;    // place the next character in the output register
  } b2da_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_digit;  // the digit pointer is at the least significant digit
    logic out_free;    // the output register can take a character this cycle
  } b2da_sts_t;

endpackage

[sv/b2da_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the decimal ASCII converter.
// Depends on b2da_pkg for the result field widths.
interface b2da_in_if
  import b2da_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2da_out_if
  import b2da_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  ascii_char;
  logic               last_char;
  logic [COUNT_W-1:0] digit_count;

  modport source (output valid, output ascii_char, output last_char,
                  output digit_count, input ready);
  modport sink   (input valid, input ascii_char, input last_char,
                  input digit_count, output ready);
endinterface

[sv/binary_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// Top level of the unsigned binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_if, b2da_ctrl and b2da_dp.
//
// Each accepted value is turned into its decimal digits as ASCII characters,
// most significant first, with no leading zeros; zero gives a single '0'.
// Every character item carries a last flag on the final digit and the total
// digit count. One value is handled at a time: after acceptance the
// double-dabble register takes VALUE_WIDTH adjust-and-shift steps, a count
// step finds the leading digit, and then one character leaves per cycle while the
// sink is ready. The input is ready again as soon as the last character sits in
// the output register. Values wider than 49 bits can have more than fifteen
// digits, in which case digit_count wraps.
module binary_to_decimal_ascii
  import b2da_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  b2da_in_if.sink    in_ch,
  b2da_out_if.source out_ch
);

  b2da_cmd_t cmd;
  b2da_sts_t sts;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  // Sequencing of one value.
  b2da_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Conversion and character output.
  b2da_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_value (in_ch.value),
    .out_ch   (out_ch)
  );

endmodule

[sv/b2da_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the decimal ASCII converter: sequences load, conversion,
// digit count and character emission. Depends on b2da_pkg.
module b2da_ctrl
  import b2da_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  b2da_sts_t sts,
  output b2da_cmd_t cmd
);

  localparam int STEP_W = $clog2(VALUE_WIDTH);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_WIDTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_CNT  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // Next state, step counter and commands.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        step_nxt  = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_CNT;
        end
      end
      ST_CNT: begin
        cmd.count = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
        if (sts.out_free && sts.last_digit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

[sv/b2da_dp.sv]
`timescale 1ns / 1ps
// Datapath of the decimal ASCII converter: double-dabble shift register,
// leading digit search, digit pointer and output register. Depends on b2da_pkg.
module b2da_dp
  import b2da_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  b2da_cmd_t              cmd,
  output b2da_sts_t              sts,
  input  logic [VALUE_WIDTH-1:0] in_value,
  b2da_out_if.source             out_ch
);

  localparam int NUM_DIGITS = b2da_num_digits(VALUE_WIDTH);
  localparam int BCD_W      = DIGIT_W * NUM_DIGITS;
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int CNT_W      = $clog2(NUM_DIGITS + 1);

  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [BCD_W-1:0]       bcd_adj;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0]       top_idx;
  logic [DIGIT_W-1:0]     cur_digit;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      char_r, char_nxt;
  logic                   last_r, last_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;

  // Add three to every BCD digit of five or more ahead of the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[DIGIT_W*i +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[DIGIT_W*i +: DIGIT_W] = bcd_r[DIGIT_W*i +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[DIGIT_W*i +: DIGIT_W] = bcd_r[DIGIT_W*i +: DIGIT_W];
      end
    end
  end

  // Position of the most significant nonzero digit; zero when all are zero.
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (bcd_r[DIGIT_W*i +: DIGIT_W] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd_r[DIGIT_W*idx_r +: DIGIT_W];

  // Conversion registers and digit pointer.
  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      bin_nxt = in_value;
      bcd_nxt = '0;
    end else if (cmd.shift) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VALUE_WIDTH-1]};
      bin_nxt = {bin_r[VALUE_WIDTH-2:0], 1'b0};
    end else if (cmd.count) begin
      idx_nxt = top_idx;
      cnt_nxt = CNT_W'(top_idx) + CNT_W'(1);
    end else if (cmd.emit && idx_r != '0) begin
      idx_nxt = idx_r - 1'b1;
    end
  end

  // Output register: loaded on emit, emptied when the sink takes the item.
  always_comb begin
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      char_nxt      = ASCII_ZERO + CHAR_W'(cur_digit);
      last_nxt      = (idx_r == '0);
      count_nxt     = COUNT_W'(cnt_r);
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    bin_r   <= bin_nxt;
    bcd_r   <= bcd_nxt;
    idx_r   <= idx_nxt;
    cnt_r   <= cnt_nxt;
    char_r  <= char_nxt;
    last_r  <= last_nxt;
    count_r <= count_nxt;
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.last_digit = (idx_r == '0);
  assign sts.out_free   = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ascii_char  = char_r;
  assign out_ch.last_char   = last_r;
  assign out_ch.digit_count = count_r;

endmodule

[sv/b2da_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the decimal ASCII converter, bound to the top level.
// Depends on b2da_pkg and binary_to_decimal_ascii_defines.svh.
`include "binary_to_decimal_ascii_defines.svh"

module b2da_chk
  import b2da_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [CHAR_W-1:0]      ascii_char,
  input logic                   last_char,
  input logic [COUNT_W-1:0]     digit_count
);

  logic               first_r;
  logic [COUNT_W-1:0] taken_r;
  logic               out_take;
  logic               in_take;
  logic               is_digit;
  logic               lead_pos;
  logic               count_ok;

  assign out_take = out_valid && out_ready;
  assign in_take  = in_valid && in_ready;

  // Conditions that the assertions below look at.
  assign is_digit = (ascii_char >= ASCII_ZERO) && (ascii_char <= ASCII_ZERO + CHAR_W'(9));
  assign lead_pos = out_valid && first_r && !last_char;
  assign count_ok = (digit_count == taken_r + 1'b1);

  // Track the position of the next character within its value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      taken_r <= '0;
    end else if (out_take) begin
      first_r <= last_char;
      taken_r <= last_char ? '0 : taken_r + 1'b1;
    end
  end

  `B2DA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result item dropped")
  `B2DA_ASSERT_SAME(a_digit_range, out_valid, is_digit, "character is not a decimal digit")
  `B2DA_ASSERT_SAME(a_no_lead_zero, lead_pos, ascii_char != ASCII_ZERO, "leading zero emitted")
  `B2DA_ASSERT_SAME(a_count_match, out_take && last_char, count_ok, "digit count is wrong")
  `B2DA_ASSERT_NEXT(a_busy_after_load, in_take, !in_ready, "value accepted during conversion")

endmodule

bind binary_to_decimal_ascii b2da_chk #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_b2da_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .ascii_char  (out_ch.ascii_char),
  .last_char   (out_ch.last_char),
  .digit_count (out_ch.digit_count)
);

[sim/binary_to_decimal_ascii_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_if and binary_to_decimal_ascii from the RTL.
module binary_to_decimal_ascii_test;
  import b2da_pkg::*;

  localparam int VALUE_W     = DEF_VALUE_WIDTH;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 60;

  // One decimal character as the result channel carries it.
  typedef struct packed {
    logic [CHAR_W-1:0]  ascii_char;
    logic               last_char;
    logic [COUNT_W-1:0] digit_count;
  } char_item_t;

  logic clk;
  logic rst_n;

  b2da_in_if #(.VALUE_WIDTH(VALUE_W)) in_ch ();
  b2da_out_if out_ch ();

  binary_to_decimal_ascii #(
    .VALUE_WIDTH(VALUE_W)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Characters still owed by the block, oldest first.
  char_item_t expected_chars[$];

  int          send_idle_pct;
  int          recv_stall_pct;
  int          error_count;
  int          values_sent;
  int          chars_checked;
  int          stalled_cycles;
  logic [20:0] lengths_seen;

  // Clock with a 12 ns period.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Appends the decimal characters of one value to the expected queue.
  function automatic void predict_decimal_chars(input logic [VALUE_W-1:0] value);
    logic [3:0]         digits[20];
    logic [VALUE_W-1:0] rest;
    int                 ndig;
    char_item_t         item;
    rest = value;
    ndig = 0;
    do begin
      digits[ndig] = 4'(rest % 10);
      rest         = rest / 10;
      ndig++;
    end while (rest != 0 && ndig < 20);
    for (int k = 0; k < ndig; k++) begin
      item.ascii_char  = CHAR_W'(digits[ndig - 1 - k]) + ASCII_ZERO;
      item.last_char   = (k == ndig - 1);
      item.digit_count = COUNT_W'(ndig);
      expected_chars.push_back(item);
    end
    lengths_seen[ndig] = 1'b1;
  endfunction

  // Result receiver: ready follows the current stall rate.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Checks every accepted character against the oldest expectation.
  always @(posedge clk) begin
    char_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character item: ascii_char %0d, last_char %0b, digit_count %0d",
               out_ch.ascii_char, out_ch.last_char, out_ch.digit_count);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (out_ch.ascii_char !== want.ascii_char) begin
          $error("ascii_char mismatch: expected %0d, actual %0d",
                 want.ascii_char, out_ch.ascii_char);
          error_count++;
        end
        if (out_ch.last_char !== want.last_char) begin
          $error("last_char mismatch: expected %0b, actual %0b",
                 want.last_char, out_ch.last_char);
          error_count++;
        end
        if (out_ch.digit_count !== want.digit_count) begin
          $error("digit_count mismatch: expected %0d, actual %0d",
                 want.digit_count, out_ch.digit_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no item moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles, %0d characters outstanding",
                 STALL_LIMIT, expected_chars.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offers one value, with random idle cycles ahead of it, and waits for acceptance.
  // Valid stays high after acceptance so back-to-back items need no extra edge.
  task automatic send_value(input logic [VALUE_W-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_decimal_chars(value);
    values_sent++;
  endtask

  // Random value shaped so that every digit length turns up often.
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] pow;
    int                 pick;
    pick = $urandom_range(0, 9);
    if (pick <= 3) begin
      return $urandom;
    end else if (pick <= 7) begin
      return $urandom >> $urandom_range(1, 31);
    end else if (pick == 8) begin
      // Just around a power of ten, where the digit count changes.
      pow = 1;
      repeat ($urandom_range(1, 9)) pow = pow * 10;
      return pow + $urandom_range(0, 4) - 2;
    end else begin
      return $urandom_range(0, 20);
    end
  endfunction

  // Zero, one, nine, the largest value, the top bit alone and bit patterns that toggle every input bit.
  task automatic test_extremes();
    send_value('0);
    send_value(1);
    send_value(9);
    send_value({VALUE_W{1'b1}});
    send_value({1'b1, {(VALUE_W - 1){1'b0}}});
    send_value({(VALUE_W / 2){2'b10}});
    send_value({(VALUE_W / 2){2'b01}});
  endtask

  // Both sides of each point where the digit count grows.
  task automatic test_digit_boundaries();
    logic [VALUE_W-1:0] pow;
    pow = 1;
    for (int k = 1; k <= 9; k++) begin
      pow = pow * 10;
      send_value(pow - 1);
      send_value(pow);
    end
  endtask

  task automatic test_random_values(input int count);
    repeat (count) send_value(random_value());
  endtask

  // Short bursts, each followed by a pause until every character has come out.
  task automatic test_pause_until_drained();
    repeat (3) begin
      repeat ($urandom_range(1, 5)) send_value(random_value());
      in_ch.valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clk);
    end
  endtask

  // Stops the sender, lets the block settle and reports the verdict.
  task automatic finish_run();
    in_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Converted %0d values into %0d checked characters.", values_sent, chars_checked);
    $display("Digit lengths seen (bit n set for n digits): %b", lengths_seen[10:1]);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.value    = '0;
    send_idle_pct  = 10;
    recv_stall_pct = 58;
    error_count    = 0;
    values_sent    = 0;
    chars_checked  = 0;
    stalled_cycles = 0;
    lengths_seen   = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender mostly busy, receiver stalling often.
    test_extremes();
    test_digit_boundaries();
    test_random_values(100);

    // Sender idling often, receiver mostly ready.
    send_idle_pct  = 58;
    recv_stall_pct = 10;
    test_pause_until_drained();
    test_random_values(90);

    // Full throughput on both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_values(90);

    finish_run();
  end

endmodule

[sim.f]
+incdir+sv
sv/b2da_pkg.sv
sv/b2da_if.sv
sv/b2da_ctrl.sv
sv/b2da_dp.sv
sv/binary_to_decimal_ascii.sv
sv/b2da_chk.sv
sim/binary_to_decimal_ascii_test.sv
